### hdl/dhlw_pkg.sv
`timescale 1ns / 1ps
package dhlw_pkg;
    localparam logic [31:0] PI_Q29      = 32'd1686629713;
    localparam logic [31:0] HALF_PI_Q29 = 32'd843314857;
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;
    localparam logic signed [33:0] TWO_Q30  = 34'sd2147483648;
    localparam logic signed [35:0] FOUR_Q30 = 36'sd4294967296;

    localparam logic [2:0] REG_MAX_DEGREE   = 3'd0;
    localparam logic [2:0] REG_FIRST_ROW    = 3'd1;
    localparam logic [2:0] REG_ROW_COUNT    = 3'd2;
    localparam logic [2:0] REG_NORTH_ROWS   = 3'd3;
    localparam logic [2:0] REG_EQ_THRESHOLD = 3'd4;

    // arctangent table in q4.30, exact powers of two past the head
    function automatic logic signed [33:0] atan_q30(input logic [5:0] i);
        logic signed [33:0] r;
        begin
            unique case (i)
                6'd0: r = 34'sd843314857;
                6'd1: r = 34'sd497837829;
                6'd2: r = 34'sd263043837;
                6'd3: r = 34'sd133525159;
                6'd4: r = 34'sd67021687;
                6'd5: r = 34'sd33543516;
                6'd6: r = 34'sd16775851;
                6'd7: r = 34'sd8388437;
                6'd8: r = 34'sd4194283;
                6'd9: r = 34'sd2097149;
                default: r = (i <= 6'd30) ? (34'sd1 <<< (6'd30 - i)) : 34'sd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [33:0] sat2(input logic signed [35:0] v);
        begin
            if (v > 36'sd2147483648) return TWO_Q30;
            if (v < -36'sd2147483648) return -TWO_Q30;
            return v[33:0];
        end
    endfunction
endpackage

### hdl/dhlw_divider.sv
`timescale 1ns / 1ps
// unsigned restoring divider, one quotient bit per cycle
module dhlw_divider
    import dhlw_pkg::*;
#(
    parameter int N_W = 64,
    parameter int D_W = 48
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic           done,
    output logic [N_W-1:0] quo
);
    localparam int CW = $clog2(N_W + 1);
    logic [N_W-1:0] q_reg, q_next;
    logic [D_W:0]   r_reg, r_next;
    logic [D_W-1:0] d_reg, d_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next, done_reg, done_next;
    logic [D_W:0]   trial;

    always_comb
    begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        trial = {r_reg[D_W-1:0], q_reg[N_W-1]};
        if (start)
        begin
            q_next = num; r_next = '0; d_next = den;
            cnt_next = CW'(N_W); busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[N_W-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end
            else
                r_next = trial;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule

### hdl/dh_grid_latitude_weight.sv
`timescale 1ns / 1ps
// channel   | signals                                   | direction
// in        | in_valid, in_ready, row_offset            | input word
// out       | out_valid, out_ready, north_slot..is_last | result word
// cfg       | cfg_we, cfg_index, cfg_wdata              | register write
// one word runs from acceptance through the co-latitude division, the cordic, the
// harmonic recurrence and the weight division to the output register, and the sequencer
// returns to idle before the next word; every division runs through the shared divider
// at one bit a cycle; a row whose product is not positive skips the weight division
// in_ready is high only while the sequencer is idle
// reset clears the registers to their defaults, the sequencer to idle, the output empty
// a result waits in the output register until out_ready; a second finished result
// waits in the sequencer and holds the input off until the output register frees up
module dh_grid_latitude_weight
    import dhlw_pkg::*;
#(
    parameter int MAX_DEGREE   = 1023,
    parameter int CORDIC_STEPS = 30
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [10:0]         row_offset,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [10:0]         north_slot,
    output logic signed [30:0]  latitude,
    output logic [31:0]         weight,
    output logic [11:0]         south_slot,
    output logic                mirror_valid,
    output logic                is_last,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [28:0]         cfg_wdata
);
    localparam logic [3:0] S_IDLE = 4'd0, S_TDIV = 4'd1, S_TWAIT = 4'd2,
        S_CORD = 4'd3, S_REC1 = 4'd4, S_REC2 = 4'd5, S_KDIV = 4'd6,
        S_KWAIT = 4'd7, S_PMUL = 4'd8, S_WDIV = 4'd9, S_WWAIT = 4'd10,
        S_OUT = 4'd11;
    localparam int SW = $clog2(CORDIC_STEPS + 1);

    // config registers
    logic [9:0]  max_degree_reg;
    logic [10:0] first_row_reg;
    logic [11:0] row_count_reg, north_rows_reg;
    logic [28:0] eq_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_degree_reg <= '0; first_row_reg <= '0; row_count_reg <= '0;
            north_rows_reg <= '0; eq_thr_reg <= 29'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_DEGREE:   max_degree_reg <= cfg_wdata[9:0];
                REG_FIRST_ROW:    first_row_reg  <= cfg_wdata[10:0];
                REG_ROW_COUNT:    row_count_reg  <= cfg_wdata[11:0];
                REG_NORTH_ROWS:   north_rows_reg <= cfg_wdata[11:0];
                REG_EQ_THRESHOLD: eq_thr_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // degree clamped by parameter
    logic [9:0]  deg;
    logic [10:0] len_l;
    assign deg = (32'(max_degree_reg) > MAX_DEGREE) ? 10'(MAX_DEGREE) : max_degree_reg;
    assign len_l = {1'b0, deg} + 11'd1;

    logic [3:0]  st_reg, st_next;
    logic [10:0] off_reg;
    logic signed [33:0] x_reg, y_reg, z_reg, s0_reg, s1_reg, sin_reg, c2_reg;
    logic signed [35:0] acc_reg;
    logic signed [67:0] p_reg;
    logic [SW-1:0] i_reg;
    logic [9:0]  k_reg;
    logic signed [31:0] lat_reg;
    logic        kneg_reg;

    // output register
    logic        out_vld_reg;
    logic [10:0] out_north_reg;
    logic signed [30:0] out_lat_reg;
    logic [31:0] out_w_reg;
    logic [11:0] out_south_reg;
    logic        out_mirror_reg, out_last_reg;
    logic        out_load;

    // shared divider
    logic        dv_start, dv_done;
    logic [63:0] dv_num, dv_quo;
    logic [47:0] dv_den;

    dhlw_divider #(.N_W(64), .D_W(48)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num),
        .den(dv_den), .done(dv_done), .quo(dv_quo)
    );

    // shared multiplier: c2 * s1 rounded, or sin * acc
    logic signed [67:0] prod;
    logic signed [35:0] rec;
    assign prod = (st_reg == S_PMUL) ? 68'(sin_reg) * 68'(acc_reg)
                                     : 68'(c2_reg) * 68'(s1_reg);
    assign rec  = 36'((prod + 68'sd536870912) >>> 30) - 36'(s0_reg);

    // global row, clamped at the south pole
    logic [11:0] g;
    always_comb
    begin
        g = {1'b0, first_row_reg} + {1'b0, off_reg};
        if (g > {len_l, 1'b0}) g = {len_l, 1'b0};
    end

    // latitude from the co-latitude quotient
    logic signed [33:0] lat_new;
    assign lat_new = $signed({2'b00, HALF_PI_Q29}) - $signed({2'b00, dv_quo[31:0]});

    logic signed [33:0] dx, dy, at;
    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;
    assign at = atan_q30(6'(i_reg));

    // one cordic rotation
    logic signed [33:0] x_step, y_step, z_step, sin_clamp;
    always_comb
    begin
        if (!z_reg[33])
        begin
            x_step = x_reg - dx; y_step = y_reg + dy; z_step = z_reg - at;
        end
        else
        begin
            x_step = x_reg + dx; y_step = y_reg - dy; z_step = z_reg + at;
        end
    end
    assign sin_clamp = x_step[33] ? '0 : ((x_step > ONE_Q30) ? ONE_Q30 : x_step);

    logic [11:0] twok1;
    assign twok1 = {1'b0, k_reg, 1'b1};
    logic [33:0] s2abs;
    assign s2abs = s1_reg[33] ? 34'(-s1_reg) : 34'(s1_reg);

    // running sum with the divided term added back with its sign
    logic signed [35:0] kq, acc_sum;
    assign kq      = $signed({2'b00, dv_quo[33:0]});
    assign acc_sum = kneg_reg ? acc_reg - kq : acc_reg + kq;

    logic [31:0] lat_abs;
    assign lat_abs = lat_reg[31] ? 32'(-lat_reg) : 32'(lat_reg);

    always_comb
    begin
        dv_start = 1'b0; dv_num = '0; dv_den = '0;
        unique case (st_reg)
            S_TDIV:
            begin
                dv_start = 1'b1;
                dv_num = 64'(PI_Q29) * 64'(g) + 64'(len_l);
                dv_den = 48'({len_l, 1'b0});
            end
            S_KDIV:
            begin
                dv_start = 1'b1;
                dv_num = 64'(s2abs);
                dv_den = 48'(twok1);
            end
            S_WDIV:
            begin
                dv_start = 1'b1;
                dv_num = 64'(p_reg) + {25'd0, len_l, 28'd0};
                dv_den = {8'd0, len_l, 29'd0};
            end
            default: ;
        endcase
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE:  if (in_valid) st_next = S_TDIV;
            S_TDIV:  st_next = S_TWAIT;
            S_TWAIT: if (dv_done) st_next = S_CORD;
            S_CORD:  if (32'(i_reg) == CORDIC_STEPS - 1 || CORDIC_STEPS == 0)
                         st_next = (deg == 10'd0) ? S_PMUL : S_REC1;
            S_REC1:  st_next = S_REC2;
            S_REC2:  st_next = S_KDIV;
            S_KDIV:  st_next = S_KWAIT;
            S_KWAIT: if (dv_done) st_next = (k_reg == deg) ? S_PMUL : S_REC1;
            S_PMUL:  st_next = (prod[67] || prod == '0) ? S_OUT : S_WDIV;
            S_WDIV:  st_next = S_WWAIT;
            S_WWAIT: if (dv_done) st_next = S_OUT;
            S_OUT:   if (!out_vld_reg || out_ready) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) st_reg <= S_IDLE;
        else        st_reg <= st_next;
    end

    logic [31:0] w_reg;

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            S_IDLE:
                if (in_valid) off_reg <= row_offset;
            S_TWAIT:
                if (dv_done)
                begin
                    lat_reg <= lat_new[31:0];
                    x_reg <= GAIN_Q30;
                    y_reg <= '0;
                    z_reg <= -(lat_new <<< 1);
                    i_reg <= '0;
                end
            S_CORD:
            begin
                x_reg <= x_step; y_reg <= y_step; z_reg <= z_step;
                i_reg <= i_reg + 1'b1;
            end
            S_REC1, S_REC2:
            begin
                s0_reg <= s1_reg;
                s1_reg <= sat2(rec);
            end
            S_KDIV:
                kneg_reg <= s1_reg[33];
            S_KWAIT:
                if (dv_done)
                begin
                    // final clamp of the sum on the last harmonic
                    if (k_reg == deg)
                        acc_reg <= (acc_sum > FOUR_Q30) ? FOUR_Q30
                                 : ((acc_sum < -FOUR_Q30) ? -FOUR_Q30 : acc_sum);
                    else
                        acc_reg <= acc_sum;
                    k_reg <= k_reg + 1'b1;
                end
            S_PMUL:
            begin
                w_reg <= '0;
                p_reg <= prod;
            end
            S_WWAIT:
                if (dv_done) w_reg <= (dv_quo[63:32] != '0) ? '1 : dv_quo[31:0];
            default: ;
        endcase
        // cordic done: load recurrence start from the last rotation
        if (st_reg == S_CORD && st_next != S_CORD)
        begin
            sin_reg <= sin_clamp;
            c2_reg  <= sat2(-36'(y_step) * 2);
            s0_reg  <= '0;
            s1_reg  <= sin_clamp;
            acc_reg <= (deg == 10'd0) ? 36'(ONE_Q30) : 36'(sin_clamp);
            k_reg   <= 10'd1;
        end
    end

    // mirror flag for the current row
    logic mirror;
    always_comb
    begin
        mirror = !(first_row_reg == '0 && off_reg == '0);
        if (lat_abs <= 32'(eq_thr_reg)) mirror = 1'b0;
    end

    // finished row moves into the output register once that is free
    assign out_load = (st_reg == S_OUT) && (!out_vld_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)        out_vld_reg <= 1'b0;
        else if (out_load) out_vld_reg <= 1'b1;
        else if (out_ready) out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_north_reg  <= off_reg;
            out_lat_reg    <= lat_reg[30:0];
            out_w_reg      <= w_reg;
            out_mirror_reg <= mirror;
            out_south_reg  <= mirror ? (row_count_reg - 12'd1 - {1'b0, off_reg}
                                        + {11'd0, first_row_reg == '0}) : 12'd0;
            out_last_reg   <= ({1'b0, off_reg} + 12'd1 == north_rows_reg);
        end
    end

    assign in_ready     = (st_reg == S_IDLE);
    assign out_valid    = out_vld_reg;
    assign north_slot   = out_north_reg;
    assign latitude     = out_lat_reg;
    assign weight       = out_w_reg;
    assign mirror_valid = out_mirror_reg;
    assign south_slot   = out_south_reg;
    assign is_last      = out_last_reg;
endmodule
